// File: hw/rtl/ncf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ncf_pkg;

  localparam logic signed [31:0] Q_ONE = 32'sd16777216;
  // cube roots of unity, Q8.24, one bit wider for the distance terms
  localparam logic signed [32:0] ROOT0_X = 33'sd16777216;
  localparam logic signed [32:0] ROOT12_X = -33'sd8388608;
  localparam logic signed [32:0] ROOT1_Y = 33'sd14529495;
  localparam logic signed [32:0] ROOT2_Y = -33'sd14529495;
  localparam logic [7:0] COLOR_FULL = 8'd200;

  typedef enum logic [2:0] {
    REG_X_ORIGIN   = 3'd0,
    REG_X_STEP     = 3'd1,
    REG_Y_ORIGIN   = 3'd2,
    REG_Y_STEP     = 3'd3,
    REG_MAX_ITER   = 3'd4,
    REG_TOLERANCE  = 3'd5,
    REG_DERIV_FLR  = 3'd6
  } ncf_reg_t;

  typedef enum logic [4:0] {
    OP_INIT_X, OP_INIT_Y, OP_INIT_T,
    OP_Z_RR, OP_Z_II, OP_Z_RI,
    OP_Z3_A, OP_Z3_B, OP_Z3_C, OP_Z3_D,
    OP_DEN_R, OP_DEN_I,
    OP_NUM_A, OP_NUM_B, OP_NUM_C, OP_NUM_D,
    OP_STEP_R, OP_STEP_I,
    OP_D0X, OP_D0Y, OP_D1X, OP_D1Y, OP_D2X, OP_D2Y
  } ncf_op_t;

  typedef enum logic [1:0] {
    ROOT_NONE  = 2'd0,
    ROOT_ONE   = 2'd1,
    ROOT_UPPER = 2'd2,
    ROOT_LOWER = 2'd3
  } ncf_root_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       wb;
    ncf_op_t    op;
    logic       advance;
    logic       div_start;
    logic       shade_start;
    logic       out_load;
    logic       found;
    logic [7:0] iters;
  } ncf_cmd_t;

  typedef struct packed {
    logic abandon;
    logic conv;
    logic div_busy;
    logic shade_busy;
  } ncf_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ncf_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ncf_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [63:0]        num,
  input  wire logic               neg,
  input  wire logic [63:0]        den,
  output logic                    busy,
  output logic signed [31:0]      quo
);
  import ncf_pkg::*;

  logic [64:0] rem_r;
  logic [31:0] lo_r;
  logic [31:0] q_r;
  logic [63:0] d_r;
  logic [5:0]  cnt_r;
  logic        ovf_r;
  logic        neg_r;
  logic        busy_r;

  logic [64:0] rem2;
  logic        ge;
  logic [32:0] mag;
  logic        big;

  assign rem2 = {rem_r[63:0], lo_r[31]};
  assign ge   = rem2 >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd32;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  // quotient of num * 2^24 / den, one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {9'b0, num[63:8]};
      lo_r  <= {num[7:0], 24'b0};
      q_r   <= '0;
      d_r   <= den;
      ovf_r <= {8'b0, num[63:8]} >= den;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= ge ? (rem2 - {1'b0, d_r}) : rem2;
      lo_r  <= {lo_r[30:0], 1'b0};
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign mag  = ovf_r ? 33'h1_0000_0000 : {1'b0, q_r};
  assign big  = mag[32] | mag[31];
  assign busy = busy_r;

  always_comb begin
    if (neg_r) begin
      quo = big ? 32'sh80000000 : -$signed(q_r);
    end else begin
      quo = big ? 32'sh7fffffff : $signed(q_r);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/ncf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ncf_dp #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ncf_pkg::ncf_cmd_t     cmd,
  output ncf_pkg::ncf_sts_t          sts,
  input  wire logic signed [31:0]    x_origin,
  input  wire logic signed [31:0]    x_step,
  input  wire logic signed [31:0]    y_origin,
  input  wire logic signed [31:0]    y_step,
  input  wire logic [7:0]            max_iterations,
  input  wire logic [30:0]           tolerance,
  input  wire logic [47:0]           deriv_floor,
  input  wire logic [COORD_BITS-1:0] pixel_col,
  input  wire logic [COORD_BITS-1:0] pixel_row,
  output logic [1:0]                 root_found,
  output logic [7:0]                 iterations_used,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue
);
  import ncf_pkg::*;

  logic [COORD_BITS-1:0] col_r, row_r;
  logic signed [65:0] prod_r;
  logic signed [39:0] t_r;
  logic signed [63:0] w_r;
  logic signed [31:0] zr_r, zi_r, z2r_r, z2i_r, fr_r, fi_r;
  logic [63:0] den_r;
  logic [61:0] tol2_r;
  logic [63:0] nr_r, ni_r;
  logic        nrneg_r, nineg_r;
  logic        conv_r;
  logic [63:0] best_r;
  ncf_root_t   root_r;
  logic [7:0]  sh_rem_r, sh_lo_r, sh_q_r;
  logic [3:0]  sh_cnt_r;
  logic        sh_busy_r;
  logic [1:0]  root_o_r;
  logic [7:0]  iters_o_r, red_r, green_r, blue_r;

  logic signed [32:0] opa, opb;
  logic signed [39:0] q;
  logic signed [31:0] q_diff, q_sum, pr, pi, sr, si, nzr, nzi;
  logic signed [64:0] nsum, ndif;
  logic [64:0] nsum_abs, ndif_abs;
  logic [63:0] usum;
  logic signed [32:0] dx0, dx1, dy0, dy1, dy2;
  logic        div_busy_r, div_busy_i;
  logic [15:0] sh_n;
  logic [8:0]  sh_rem2;
  logic        sh_ge;

  assign q      = prod_r[63:24];
  assign q_diff = sat32(50'(t_r) - 50'(q));
  assign q_sum  = sat32(50'(t_r) + 50'(q));
  assign pr     = sat32(50'(z2r_r) * 50'sd3);
  assign pi     = sat32(50'(z2i_r) * 50'sd3);
  assign nsum   = 65'(w_r) + 65'($signed(prod_r[63:0]));
  assign ndif   = 65'(w_r) - 65'($signed(prod_r[63:0]));
  assign nsum_abs = nsum[64] ? 65'(-nsum) : 65'(nsum);
  assign ndif_abs = ndif[64] ? 65'(-ndif) : 65'(ndif);
  assign usum   = w_r + prod_r[63:0];
  assign nzr    = sat32(50'(zr_r) - 50'(sr));
  assign nzi    = sat32(50'(zi_r) - 50'(si));
  assign dx0    = 33'(nzr) - ROOT0_X;
  assign dx1    = 33'(nzr) - ROOT12_X;
  assign dy0    = 33'(nzi);
  assign dy1    = 33'(nzi) - ROOT1_Y;
  assign dy2    = 33'(nzi) - ROOT2_Y;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.op)
      OP_INIT_X: begin
        opa = {{(33-COORD_BITS){1'b0}}, col_r};
        opb = 33'(x_step);
      end
      OP_INIT_Y: begin
        opa = {{(33-COORD_BITS){1'b0}}, row_r};
        opb = 33'(y_step);
      end
      OP_INIT_T: begin
        opa = {2'b0, tolerance};
        opb = {2'b0, tolerance};
      end
      OP_Z_RR:   begin opa = 33'(zr_r);  opb = 33'(zr_r); end
      OP_Z_II:   begin opa = 33'(zi_r);  opb = 33'(zi_r); end
      OP_Z_RI:   begin opa = 33'(zr_r);  opb = 33'(zi_r); end
      OP_Z3_A:   begin opa = 33'(z2r_r); opb = 33'(zr_r); end
      OP_Z3_B:   begin opa = 33'(z2i_r); opb = 33'(zi_r); end
      OP_Z3_C:   begin opa = 33'(z2r_r); opb = 33'(zi_r); end
      OP_Z3_D:   begin opa = 33'(z2i_r); opb = 33'(zr_r); end
      OP_DEN_R:  begin opa = 33'(pr);    opb = 33'(pr);   end
      OP_DEN_I:  begin opa = 33'(pi);    opb = 33'(pi);   end
      OP_NUM_A:  begin opa = 33'(fr_r);  opb = 33'(pr);   end
      OP_NUM_B:  begin opa = 33'(fi_r);  opb = 33'(pi);   end
      OP_NUM_C:  begin opa = 33'(fi_r);  opb = 33'(pr);   end
      OP_NUM_D:  begin opa = 33'(fr_r);  opb = 33'(pi);   end
      OP_STEP_R: begin opa = 33'(sr);    opb = 33'(sr);   end
      OP_STEP_I: begin opa = 33'(si);    opb = 33'(si);   end
      OP_D0X:    begin opa = dx0;        opb = dx0;       end
      OP_D0Y:    begin opa = dy0;        opb = dy0;       end
      OP_D1X:    begin opa = dx1;        opb = dx1;       end
      OP_D1Y:    begin opa = dy1;        opb = dy1;       end
      OP_D2X:    begin opa = dx1;        opb = dx1;       end
      OP_D2Y:    begin opa = dy2;        opb = dy2;       end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r <= pixel_col;
      row_r <= pixel_row;
    end
    if (cmd.mul) begin
      prod_r <= opa * opb;
    end
    if (cmd.advance) begin
      zr_r <= nzr;
      zi_r <= nzi;
    end else if (cmd.wb) begin
      unique case (cmd.op)
        OP_INIT_X: zr_r <= sat32(50'($signed(prod_r[48:0])) + 50'(x_origin));
        OP_INIT_Y: zi_r <= sat32(50'($signed(prod_r[48:0])) + 50'(y_origin));
        OP_INIT_T: tol2_r <= prod_r[61:0];
        OP_Z_RR:   t_r <= q;
        OP_Z_II:   z2r_r <= q_diff;
        OP_Z_RI:   z2i_r <= sat32(50'(q) + 50'(q));
        OP_Z3_A:   t_r <= q;
        OP_Z3_B:   fr_r <= sat32(50'(q_diff) - 50'(Q_ONE));
        OP_Z3_C:   t_r <= q;
        OP_Z3_D:   fi_r <= q_sum;
        OP_DEN_R:  w_r <= prod_r[63:0];
        OP_DEN_I:  den_r <= usum;
        OP_NUM_A:  w_r <= prod_r[63:0];
        OP_NUM_B: begin
          nr_r    <= nsum_abs[63:0];
          nrneg_r <= nsum[64];
        end
        OP_NUM_C:  w_r <= prod_r[63:0];
        OP_NUM_D: begin
          ni_r    <= ndif_abs[63:0];
          nineg_r <= ndif[64];
        end
        OP_STEP_R: w_r <= prod_r[63:0];
        OP_STEP_I: conv_r <= usum < {2'b0, tol2_r};
        OP_D0X:    w_r <= prod_r[63:0];
        OP_D0Y: begin
          best_r <= usum;
          root_r <= ROOT_ONE;
        end
        OP_D1X:    w_r <= prod_r[63:0];
        OP_D1Y: begin
          if (usum < best_r) begin
            best_r <= usum;
            root_r <= ROOT_UPPER;
          end
        end
        OP_D2X:    w_r <= prod_r[63:0];
        OP_D2Y: begin
          if (usum < best_r) begin
            root_r <= ROOT_LOWER;
          end
        end
        default: ;
      endcase
    end
  end

  ncf_div u_div_re (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (nr_r),
    .neg   (nrneg_r),
    .den   (den_r),
    .busy  (div_busy_r),
    .quo   (sr)
  );

  ncf_div u_div_im (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (ni_r),
    .neg   (nineg_r),
    .den   (den_r),
    .busy  (div_busy_i),
    .quo   (si)
  );

  // shade = 255 * iters / max_iterations, one quotient bit per cycle
  assign sh_n    = {cmd.iters, 8'b0} - {8'b0, cmd.iters};
  assign sh_rem2 = {sh_rem_r, sh_lo_r[7]};
  assign sh_ge   = sh_rem2 >= {1'b0, max_iterations};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sh_busy_r <= 1'b0;
      sh_cnt_r  <= '0;
    end else if (cmd.shade_start) begin
      sh_busy_r <= 1'b1;
      sh_cnt_r  <= 4'd8;
    end else if (sh_busy_r) begin
      sh_cnt_r <= sh_cnt_r - 4'd1;
      if (sh_cnt_r == 4'd1) begin
        sh_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shade_start) begin
      sh_rem_r <= sh_n[15:8];
      sh_lo_r  <= sh_n[7:0];
      sh_q_r   <= '0;
    end else if (sh_busy_r) begin
      sh_rem_r <= sh_ge ? 8'(sh_rem2 - {1'b0, max_iterations}) : sh_rem2[7:0];
      sh_lo_r  <= {sh_lo_r[6:0], 1'b0};
      sh_q_r   <= {sh_q_r[6:0], sh_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      iters_o_r <= cmd.iters;
      if (!cmd.found) begin
        root_o_r <= ROOT_NONE;
        red_r    <= '0;
        green_r  <= '0;
        blue_r   <= '0;
      end else begin
        root_o_r <= root_r;
        unique case (root_r)
          ROOT_ONE: begin
            red_r   <= COLOR_FULL;
            green_r <= sh_q_r;
            blue_r  <= {1'b0, sh_q_r[7:1]};
          end
          ROOT_UPPER: begin
            red_r   <= {1'b0, sh_q_r[7:1]};
            green_r <= COLOR_FULL;
            blue_r  <= sh_q_r;
          end
          ROOT_LOWER: begin
            red_r   <= sh_q_r;
            green_r <= {1'b0, sh_q_r[7:1]};
            blue_r  <= COLOR_FULL;
          end
          default: begin
            red_r   <= '0;
            green_r <= '0;
            blue_r  <= '0;
          end
        endcase
      end
    end
  end

  assign sts.abandon    = (den_r == 64'd0) || (den_r < {16'b0, deriv_floor});
  assign sts.conv       = conv_r;
  assign sts.div_busy   = div_busy_r | div_busy_i;
  assign sts.shade_busy = sh_busy_r;

  assign root_found      = root_o_r;
  assign iterations_used = iters_o_r;
  assign red             = red_r;
  assign green           = green_r;
  assign blue            = blue_r;

endmodule
`default_nettype wire

// File: hw/rtl/ncf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ncf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire logic [7:0]        max_iterations,
  output ncf_pkg::ncf_cmd_t      cmd,
  input  wire ncf_pkg::ncf_sts_t sts
);
  import ncf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MUL  = 10'b0000000010,
    S_WB   = 10'b0000000100,
    S_CHKD = 10'b0000001000,
    S_DIVS = 10'b0000010000,
    S_DIVW = 10'b0000100000,
    S_CHKC = 10'b0001000000,
    S_SHS  = 10'b0010000000,
    S_SHW  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  ncf_op_t    op_r, op_nxt;
  logic [7:0] it_r, it_nxt;
  logic [7:0] iters_r, iters_nxt;
  logic       found_r, found_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       last_iter;

  assign last_iter = ({1'b0, it_r} + 9'd1) >= {1'b0, max_iterations};

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    it_nxt    = it_r;
    iters_nxt = iters_r;
    found_nxt = found_r;
    cmd             = '0;
    cmd.op          = op_r;
    cmd.iters       = iters_r;
    cmd.found       = found_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_INIT_X;
          it_nxt    = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        unique case (op_r)
          OP_INIT_T: begin
            if (max_iterations == 8'd0) begin
              found_nxt = 1'b0;
              iters_nxt = max_iterations;
              state_nxt = S_FIN;
            end else begin
              op_nxt    = OP_Z_RR;
              state_nxt = S_MUL;
            end
          end
          OP_DEN_I:  state_nxt = S_CHKD;
          OP_NUM_D:  state_nxt = S_DIVS;
          OP_STEP_I: state_nxt = S_CHKC;
          OP_D2Y:    state_nxt = S_SHS;
          default: begin
            op_nxt    = ncf_op_t'(op_r + 5'd1);
            state_nxt = S_MUL;
          end
        endcase
      end
      S_CHKD: begin
        if (sts.abandon) begin
          found_nxt = 1'b0;
          iters_nxt = max_iterations;
          state_nxt = S_FIN;
        end else begin
          op_nxt    = OP_NUM_A;
          state_nxt = S_MUL;
        end
      end
      S_DIVS: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIVW;
      end
      S_DIVW: begin
        if (!sts.div_busy) begin
          op_nxt    = OP_STEP_R;
          state_nxt = S_MUL;
        end
      end
      S_CHKC: begin
        if (sts.conv) begin
          found_nxt = 1'b1;
          iters_nxt = it_r + 8'd1;
          op_nxt    = OP_D0X;
          state_nxt = S_MUL;
        end else begin
          cmd.advance = 1'b1;
          if (last_iter) begin
            found_nxt = 1'b0;
            iters_nxt = max_iterations;
            state_nxt = S_FIN;
          end else begin
            it_nxt    = it_r + 8'd1;
            op_nxt    = OP_Z_RR;
            state_nxt = S_MUL;
          end
        end
      end
      S_SHS: begin
        cmd.shade_start = 1'b1;
        state_nxt       = S_SHW;
      end
      S_SHW: begin
        if (!sts.shade_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_INIT_X;
      it_r        <= '0;
      iters_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      it_r        <= it_nxt;
      iters_r     <= iters_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("accepted request did not start");

  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

endmodule
`default_nettype wire

// File: hw/rtl/newton_cubic_fractal_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// Newton fractal pixel for z^3 - 1: each request carries a pixel column and
// row, the start point is origin + index * step in signed Q8.24, and up to
// max_iterations Newton steps run. A pixel that converges is labeled with
// the nearest cube root of unity and colored; any other gets no root and is
// black. One request is in work at a time, and a new one is taken while the
// previous result still waits. The datapath has one shared 33x33 multiplier
// (fifteen products per step) and a pair of one-bit-per-cycle dividers.
module newton_cubic_fractal_pixel #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [COORD_BITS-1:0] in_pixel_col,
  input  wire logic [COORD_BITS-1:0] in_pixel_row,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_root_found,
  output logic [7:0]                 out_iterations_used,
  output logic [7:0]                 out_red,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_blue,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [5:0]            paddr,
  input  wire logic [63:0]           pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);
  import ncf_pkg::*;

  logic signed [31:0] x_origin_r, x_step_r, y_origin_r, y_step_r;
  logic [7:0]         max_iter_r;
  logic [30:0]        tol_r;
  logic [47:0]        floor_r;
  logic               wr_en;
  ncf_reg_t           reg_sel;
  ncf_cmd_t           cmd;
  ncf_sts_t           sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = ncf_reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= -32'sd33554432;
      x_step_r   <= 32'sd131329;
      y_origin_r <= -32'sd33554432;
      y_step_r   <= 32'sd131329;
      max_iter_r <= 8'd20;
      tol_r      <= 31'd16777;
      floor_r    <= 48'd1;
    end else if (wr_en) begin
      case (reg_sel)
        REG_X_ORIGIN:  x_origin_r <= pwdata[31:0];
        REG_X_STEP:    x_step_r   <= pwdata[31:0];
        REG_Y_ORIGIN:  y_origin_r <= pwdata[31:0];
        REG_Y_STEP:    y_step_r   <= pwdata[31:0];
        REG_MAX_ITER:  max_iter_r <= pwdata[7:0];
        REG_TOLERANCE: tol_r      <= pwdata[30:0];
        REG_DERIV_FLR: floor_r    <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_X_ORIGIN:  prdata = {32'b0, x_origin_r};
      REG_X_STEP:    prdata = {32'b0, x_step_r};
      REG_Y_ORIGIN:  prdata = {32'b0, y_origin_r};
      REG_Y_STEP:    prdata = {32'b0, y_step_r};
      REG_MAX_ITER:  prdata = {56'b0, max_iter_r};
      REG_TOLERANCE: prdata = {33'b0, tol_r};
      REG_DERIV_FLR: prdata = {16'b0, floor_r};
      default:       prdata = '0;
    endcase
  end

  ncf_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .max_iterations (max_iter_r),
    .cmd            (cmd),
    .sts            (sts)
  );

  ncf_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .x_origin        (x_origin_r),
    .x_step          (x_step_r),
    .y_origin        (y_origin_r),
    .y_step          (y_step_r),
    .max_iterations  (max_iter_r),
    .tolerance       (tol_r),
    .deriv_floor     (floor_r),
    .pixel_col       (in_pixel_col),
    .pixel_row       (in_pixel_row),
    .root_found      (out_root_found),
    .iterations_used (out_iterations_used),
    .red             (out_red),
    .green           (out_green),
    .blue            (out_blue)
  );

endmodule
`default_nettype wire
